// ----- design/tkpl_pkg.sv -----
// Package for the touch keypad PIN lock: item and config structs, key codes,
// register indexes and keypad geometry constants. No dependencies.
`default_nettype none

package tkpl_pkg;

   // Geometry arithmetic width (signed, covers every box edge)
   localparam int GEO_W = 13;

   // Digits held in the stored PIN register
   localparam int PIN_SLOTS = 7;

   // Config register index width and indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIN_DIGITS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIN_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_GAP    = 3'd6;
   localparam int CSR_DATA_W = 28;

   // Key codes
   localparam logic [3:0] KEY_NONE = 4'd0;
   localparam logic [3:0] KEY_CLR  = 4'd10;
   localparam logic [3:0] KEY_OK   = 4'd11;

   // Third column sits left of the regular pitch
   localparam logic signed [GEO_W-1:0] COL2_SHIFT = GEO_W'(15);

   typedef struct packed {
      logic       touched;
      logic [9:0] touch_x;
      logic [9:0] touch_y;
   } req_type;

   typedef struct packed {
      logic       key_hit;
      logic [3:0] key_code;
      logic [2:0] entry_length;
      logic       entry_changed;
      logic       pin_accepted;
      logic       pin_rejected;
      logic       unlocked;
   } rsp_type;

   // Classified sample handed from front to back
   typedef struct packed {
      logic       key_hit;
      logic [3:0] key_code;
   } key_type;

   typedef struct packed {
      logic [27:0] stored_pin_digits;
      logic [2:0]  stored_pin_length;
      logic [9:0]  grid_origin_x;
      logic [9:0]  grid_origin_y;
      logic [7:0]  key_width;
      logic [7:0]  key_height;
      logic [7:0]  key_gap;
   } cfg_type;

   // Fixed extra vertical offset of each keypad row
   function automatic logic signed [GEO_W-1:0] row_extra(input logic [1:0] row);
      logic signed [GEO_W-1:0] extra;
      case (row)
         2'd0:    extra = GEO_W'(0);
         2'd1:    extra = GEO_W'(10);
         2'd2:    extra = GEO_W'(25);
         2'd3:    extra = GEO_W'(40);
         default: extra = GEO_W'(0);
      endcase
      return extra;
   endfunction

   // Row-major key index to key code: 1 2 3 / 4 5 6 / 7 8 9 / CLR 0 OK
   function automatic logic [3:0] key_code_of(input logic [3:0] idx);
      logic [3:0] code;
      case (idx)
         4'd0:    code = 4'd1;
         4'd1:    code = 4'd2;
         4'd2:    code = 4'd3;
         4'd3:    code = 4'd4;
         4'd4:    code = 4'd5;
         4'd5:    code = 4'd6;
         4'd6:    code = 4'd7;
         4'd7:    code = 4'd8;
         4'd8:    code = 4'd9;
         4'd9:    code = KEY_CLR;
         4'd10:   code = 4'd0;
         4'd11:   code = KEY_OK;
         default: code = KEY_NONE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ----- design/tkpl_queue.sv -----
// Small first-in first-out queue of fixed-width entries.
// Used between front and back and as the result buffer. No dependencies.
`default_nettype none

module tkpl_queue #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- design/tkpl_front.sv -----
// Front end: press/release confirmation and keypad hit test.
// Depends on tkpl_pkg. Emits one classified key item per accepted sample.
`default_nettype none

module tkpl_front
   import tkpl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    take,
   input  wire req_type sample,
   input  wire cfg_type cfg,
   output key_type      key
);

   logic fd_ff, fd_in;
   logic pp_ff, pp_in;
   logic rp_ff, rp_in;
   logic press;

   logic [8:0]              pitch_x, pitch_y;
   logic signed [GEO_W-1:0] px_s, py_s, ox_s, oy_s, kw_s, kh_s, tx_s, ty_s;
   logic signed [GEO_W-1:0] col_x [3];
   logic signed [GEO_W-1:0] row_y [4];
   logic [11:0]             box_hit;
   logic                    found;
   logic [3:0]              found_idx;

   // Debounce: confirm press and release over two samples
   always_comb begin
      fd_in = fd_ff;
      pp_in = pp_ff;
      rp_in = rp_ff;
      press = 1'b0;
      if (take) begin
         if (!fd_ff) begin
            if (pp_ff) begin
               pp_in = 1'b0;
               if (sample.touched) begin
                  fd_in = 1'b1;
                  rp_in = 1'b0;
                  press = 1'b1;
               end
            end else if (sample.touched) begin
               pp_in = 1'b1;
            end
         end else begin
            if (rp_ff) begin
               rp_in = 1'b0;
               if (!sample.touched) begin
                  fd_in = 1'b0;
               end
            end else if (!sample.touched) begin
               rp_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fd_ff <= 1'b0;
         pp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         fd_ff <= fd_in;
         pp_ff <= pp_in;
         rp_ff <= rp_in;
      end
   end

   // Box edges from the grid settings
   assign pitch_x = {1'b0, cfg.key_width} + {1'b0, cfg.key_gap};
   assign pitch_y = {1'b0, cfg.key_height} + {1'b0, cfg.key_gap};
   assign px_s    = $signed(GEO_W'(pitch_x));
   assign py_s    = $signed(GEO_W'(pitch_y));
   assign ox_s    = $signed(GEO_W'(cfg.grid_origin_x));
   assign oy_s    = $signed(GEO_W'(cfg.grid_origin_y));
   assign kw_s    = $signed(GEO_W'(cfg.key_width));
   assign kh_s    = $signed(GEO_W'(cfg.key_height));
   assign tx_s    = $signed(GEO_W'(sample.touch_x));
   assign ty_s    = $signed(GEO_W'(sample.touch_y));

   assign col_x[0] = ox_s;
   assign col_x[1] = ox_s + px_s;
   assign col_x[2] = ox_s + (px_s <<< 1) - COL2_SHIFT;

   assign row_y[0] = oy_s + row_extra(2'd0);
   assign row_y[1] = oy_s + py_s + row_extra(2'd1);
   assign row_y[2] = oy_s + (py_s <<< 1) + row_extra(2'd2);
   assign row_y[3] = oy_s + (py_s <<< 1) + py_s + row_extra(2'd3);

   // Test all twelve boxes in parallel, bounds inclusive
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            box_hit[r * 3 + c] = (tx_s >= col_x[c]) && (tx_s <= col_x[c] + kw_s) &&
                                 (ty_s >= row_y[r]) && (ty_s <= row_y[r] + kh_s);
         end
      end
   end

   // Pick the first box in row-major order
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int k = 11; k >= 0; k--) begin
         if (box_hit[k]) begin
            found     = 1'b1;
            found_idx = 4'(k);
         end
      end
   end

   assign key.key_hit  = press && found;
   assign key.key_code = (press && found) ? key_code_of(found_idx) : KEY_NONE;

endmodule

`default_nettype wire

// ----- design/tkpl_back.sv -----
// Back end: digit entry, clear, PIN compare and lock state.
// Depends on tkpl_pkg. Turns each classified key item into one result.
`default_nettype none

module tkpl_back
   import tkpl_pkg::*;
#(
   parameter int MAX_PIN_DIGITS = 7
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire key_type key,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   localparam int CW     = $clog2(MAX_PIN_DIGITS + 1);
   localparam int AW     = (MAX_PIN_DIGITS > 1) ? $clog2(MAX_PIN_DIGITS) : 1;
   localparam int CMP_W  = (CW > 3) ? CW : 3;
   localparam int SLOTS  = (MAX_PIN_DIGITS > PIN_SLOTS) ? MAX_PIN_DIGITS : PIN_SLOTS;
   localparam int PIN_W  = 4 * SLOTS;

   logic [3:0]       digit_ff [MAX_PIN_DIGITS];
   logic [CW-1:0]    count_ff, count_in;
   logic             lock_ff, lock_in;
   logic             wr_digit;
   logic             match;
   logic [PIN_W-1:0] pin_wide;
   logic [CMP_W-1:0] count_wide;

   assign pin_wide = PIN_W'(cfg.stored_pin_digits);

   // Compare length and every entered digit with the stored PIN
   always_comb begin
      match = (CMP_W'(count_ff) == CMP_W'(cfg.stored_pin_length));
      for (int i = 0; i < MAX_PIN_DIGITS; i++) begin
         if ((CW'(i) < count_ff) && (digit_ff[i] != pin_wide[4 * i +: 4])) begin
            match = 1'b0;
         end
      end
   end

   // Apply the key to the entry and build the result
   always_comb begin
      count_in = count_ff;
      lock_in  = lock_ff;
      wr_digit = 1'b0;
      rsp      = '0;
      if (lock_ff) begin
         rsp.unlocked = 1'b1;
      end else if (key.key_hit) begin
         rsp.key_hit  = 1'b1;
         rsp.key_code = key.key_code;
         case (key.key_code)
            KEY_CLR: begin
               count_in          = '0;
               rsp.entry_changed = 1'b1;
            end
            KEY_OK: begin
               if (match) begin
                  lock_in          = 1'b1;
                  rsp.pin_accepted = 1'b1;
               end else begin
                  count_in          = '0;
                  rsp.entry_changed = 1'b1;
                  rsp.pin_rejected  = 1'b1;
               end
            end
            default: begin
               if (count_ff < CW'(MAX_PIN_DIGITS)) begin
                  wr_digit          = 1'b1;
                  count_in          = count_ff + 1'b1;
                  rsp.entry_changed = 1'b1;
               end
            end
         endcase
      end
      rsp.unlocked     = lock_in;
      count_wide       = CMP_W'(count_in);
      rsp.entry_length = count_wide[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         lock_ff  <= 1'b0;
      end else if (fire) begin
         count_ff <= count_in;
         lock_ff  <= lock_in;
      end
   end

   // Append the digit at the current count
   always_ff @(posedge clock) begin
      if (fire && wr_digit) begin
         digit_ff[count_ff[AW-1:0]] <= key.key_code;
      end
   end

   // Once open, the lock stays open until reset
   a_lock_holds: assert property (@(posedge clock) disable iff (reset)
      lock_ff |=> lock_ff)
      else $error("lock closed without reset");

   // Entry never grows past its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_PIN_DIGITS))
      else $error("entry count above capacity");

   // Accept and reject never in the same result
   a_acc_rej: assert property (@(posedge clock) disable iff (reset)
      fire |-> !(rsp.pin_accepted && rsp.pin_rejected))
      else $error("accept and reject together");

   // An accepted PIN opens the lock on the next cycle
   a_acc_opens: assert property (@(posedge clock) disable iff (reset)
      (fire && rsp.pin_accepted) |=> lock_ff)
      else $error("accepted PIN did not open the lock");

endmodule

`default_nettype wire

// ----- design/touch_keypad_pin_lock.sv -----
// Top level of the touch keypad PIN lock: config registers, front end,
// key queue, back end and result queue. Depends on tkpl_pkg and submodules.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_push / req_full       req_item  (req_type)
//   rsp_      out        rsp_pop / rsp_empty       rsp_item  (rsp_type)
//   csr_      in         csr_valid / csr_ready     csr_index, csr_wdata
//
// One sample per cycle is accepted while req_full is low; each yields exactly
// one result. A sample is classified in the cycle of its transfer and enters
// the key queue; the back end moves its result into the result queue once that
// queue has room, and it shows on rsp_item when it reaches the queue's head.
// The back end updates the entry for one key item each time it advances.
// Reset is synchronous; it clears the queues, debounce and lock state and
// loads the config defaults. csr_ready is always high.
// A full result queue stalls the back end; the key queue then fills and
// raises req_full.
`default_nettype none

module touch_keypad_pin_lock
   import tkpl_pkg::*;
#(
   parameter int MAX_PIN_DIGITS = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire req_type               req_item,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output rsp_type                    rsp_item,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int QUEUE_DEPTH = 2;
   localparam int KEY_W       = $bits(key_type);
   localparam int RSP_W       = $bits(rsp_type);

   cfg_type          cfg_ff, cfg_in;
   logic             take;
   key_type          front_key, back_key;
   logic [KEY_W-1:0] back_key_bits;
   logic             mid_empty;
   logic             res_full;
   logic             fire;
   rsp_type          back_rsp;
   logic [RSP_W-1:0] rsp_bits;

   assign csr_ready = 1'b1;

   // Write the addressed config register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PIN_DIGITS: cfg_in.stored_pin_digits = csr_wdata;
            CSR_PIN_LENGTH: cfg_in.stored_pin_length = csr_wdata[2:0];
            CSR_ORIGIN_X:   cfg_in.grid_origin_x     = csr_wdata[9:0];
            CSR_ORIGIN_Y:   cfg_in.grid_origin_y     = csr_wdata[9:0];
            CSR_KEY_WIDTH:  cfg_in.key_width         = csr_wdata[7:0];
            CSR_KEY_HEIGHT: cfg_in.key_height        = csr_wdata[7:0];
            CSR_KEY_GAP:    cfg_in.key_gap           = csr_wdata[7:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stored_pin_digits <= 28'd0;
         cfg_ff.stored_pin_length <= 3'd4;
         cfg_ff.grid_origin_x     <= 10'd245;
         cfg_ff.grid_origin_y     <= 10'd100;
         cfg_ff.key_width         <= 8'd90;
         cfg_ff.key_height        <= 8'd65;
         cfg_ff.key_gap           <= 8'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: take a sample whenever the key queue has room
   assign take = req_push && !req_full;

   tkpl_front u_front (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .sample (req_item),
      .cfg    (cfg_ff),
      .key    (front_key)
   );

   tkpl_queue #(
      .WIDTH (KEY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_key_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (front_key),
      .full      (req_full),
      .pop       (fire),
      .empty     (mid_empty),
      .pop_data  (back_key_bits)
   );

   assign back_key = key_type'(back_key_bits);

   // Back: advance when a key waits and the result queue has room
   assign fire = !mid_empty && !res_full;

   tkpl_back #(
      .MAX_PIN_DIGITS (MAX_PIN_DIGITS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .key   (back_key),
      .cfg   (cfg_ff),
      .rsp   (back_rsp)
   );

   tkpl_queue #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data (back_rsp),
      .full      (res_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_bits)
   );

   assign rsp_item = rsp_type'(rsp_bits);

endmodule

`default_nettype wire
